FILE: rtl/gdbd_pkg.sv
// ----------------------------------------------------------------------------
// gdbd_pkg: shared types and constants for the date distance block
// field widths, arithmetic unit operand format and the calendar tables
// ----------------------------------------------------------------------------
package gdbd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int NUM_W   = 23;   // day number of any 14-bit year
   localparam int YSH_W   = 15;   // shifted year
   localparam int QUO_W   = 8;    // year / 100
   localparam int REM_W   = 8;    // uncorrected remainder, below 200

   // arithmetic unit operands and result
   localparam int A_W   = 24;
   localparam int B_W   = 13;
   localparam int RES_W = A_W + B_W + 1;

   // divide by 100 through a reciprocal that may come out one low
   localparam logic [B_W-1:0]     DIV_RECIP  = 13'd5242;
   localparam int                 DIV_SHIFT  = 19;
   localparam logic [QUO_W-1:0]   CENTURY    = 8'd100;
   localparam logic [YSH_W-1:0]   YEAR_SHIFT = 15'd400;
   localparam logic [B_W-1:0]     DAYS_YEAR  = 13'd365;
   localparam logic [B_W-1:0]     UNIT       = 13'd1;
   localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic           sub;   // c - a*b when set, c + a*b otherwise
      logic [A_W-1:0] a;
      logic [B_W-1:0] b;
      logic [A_W-1:0] c;
   } alu_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               invalid_date;
   } result_type;

   // days before the first of the month, counted from march
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      unique case (m)
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      unique case (m)
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         4'd2:                    r = leap ? 5'd29 : 5'd28;
         default:                 r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/gdbd_alu.sv
// ----------------------------------------------------------------------------
// gdbd_alu: shared multiply-accumulate unit
// gives c + a*b or c - a*b, one operation per cycle for the sequencer
// ----------------------------------------------------------------------------
module gdbd_alu
   import gdbd_pkg::*;
(
   input  alu_req_type              req,
   output logic signed [RES_W-1:0]  res
);

   logic [RES_W-1:0] prod;
   logic [RES_W-1:0] c_ext;

   assign prod  = RES_W'(req.a) * RES_W'(req.b);
   assign c_ext = RES_W'(req.c);
   assign res   = req.sub ? $signed(c_ext - prod) : $signed(c_ext + prod);

endmodule

FILE: rtl/gdbd_seq.sv
// ----------------------------------------------------------------------------
// gdbd_seq: sequencer for the day number of each date and their distance
// drives the shared unit through a fixed step list, checks both dates
// ----------------------------------------------------------------------------
module gdbd_seq
   import gdbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  date_type   first_date,
   input  date_type   second_date,
   input  logic       take,
   output logic       idle,
   output logic       done_valid,
   output result_type result
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIVY  = 4'd1;
   localparam logic [3:0] ST_REMY  = 4'd2;
   localparam logic [3:0] ST_DIVYY = 4'd3;
   localparam logic [3:0] ST_REMYY = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUBC  = 4'd6;
   localparam logic [3:0] ST_ADDQ  = 4'd7;
   localparam logic [3:0] ST_ADDMD = 4'd8;
   localparam logic [3:0] ST_DIFF1 = 4'd9;
   localparam logic [3:0] ST_DIFF2 = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]                state_ff, state_in;
   logic                      sel_ff, sel_in;
   date_type [1:0]            date_ff, date_in;
   logic [QUO_W-1:0]          q_ff, q_in;
   logic                      leap_ff, leap_in;
   logic [NUM_W-1:0]          acc_ff, acc_in;
   logic [1:0][NUM_W-1:0]     num_ff, num_in;
   logic [1:0]                ok_ff, ok_in;
   result_type                res_ff, res_in;

   alu_req_type               alu_req;
   logic signed [RES_W-1:0]   alu_res;

   date_type                  cur;
   logic [YSH_W-1:0]          yy;
   logic [QUO_W-1:0]          q_raw, q_corr;
   logic [REM_W-1:0]          r_raw, r_corr;
   logic                      corr;
   logic                      date_ok;
   logic [NUM_W-1:0]          mag;
   result_type                final_res;

   gdbd_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   assign cur = date_ff[sel_ff];
   assign yy  = YSH_W'(cur.year) + YEAR_SHIFT
              - ((cur.month <= MONTH_FEB) ? YSH_W'(1) : YSH_W'(0));

   // one-low reciprocal quotient, fixed up by one compare and subtract
   assign q_raw  = alu_res[DIV_SHIFT +: QUO_W];
   assign r_raw  = alu_res[REM_W-1:0];
   assign corr   = (r_raw >= CENTURY);
   assign q_corr = q_ff + QUO_W'(corr);
   assign r_corr = r_raw - (corr ? CENTURY : '0);

   assign date_ok = (cur.month >= MONTH_JAN) && (cur.month <= MONTH_DEC)
                 && (cur.day != '0) && (cur.day <= month_days(cur.month, leap_ff));

   assign mag = alu_res[NUM_W-1:0];

   always_comb begin
      final_res.invalid_date = !(ok_ff[0] && ok_ff[1]);
      if (!(ok_ff[0] && ok_ff[1])) begin
         final_res.day_count = '0;
      end else if (mag > NUM_W'(COUNT_MAX)) begin
         final_res.day_count = COUNT_MAX;
      end else begin
         final_res.day_count = mag[COUNT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      date_in  = date_ff;
      q_in     = q_ff;
      leap_in  = leap_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      ok_in    = ok_ff;
      res_in   = res_ff;
      alu_req  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               date_in  = {second_date, first_date};
               sel_in   = 1'b0;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            alu_req.a = A_W'(cur.year);
            alu_req.b = DIV_RECIP;
            q_in      = q_raw;
            state_in  = ST_REMY;
         end
         ST_REMY: begin
            alu_req.sub = 1'b1;
            alu_req.a   = A_W'(q_ff);
            alu_req.b   = B_W'(CENTURY);
            alu_req.c   = A_W'(cur.year);
            leap_in     = (cur.year[1:0] == 2'b00)
                       && ((r_corr != '0) || (q_corr[1:0] == 2'b00));
            state_in    = ST_DIVYY;
         end
         ST_DIVYY: begin
            alu_req.a = A_W'(yy);
            alu_req.b = DIV_RECIP;
            q_in      = q_raw;
            state_in  = ST_REMYY;
         end
         ST_REMYY: begin
            alu_req.sub = 1'b1;
            alu_req.a   = A_W'(q_ff);
            alu_req.b   = B_W'(CENTURY);
            alu_req.c   = A_W'(yy);
            q_in        = q_corr;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            alu_req.a = A_W'(yy);
            alu_req.b = DAYS_YEAR;
            alu_req.c = A_W'(yy >> 2);
            acc_in    = alu_res[NUM_W-1:0];
            state_in  = ST_SUBC;
         end
         ST_SUBC: begin
            alu_req.sub = 1'b1;
            alu_req.a   = A_W'(q_ff);
            alu_req.b   = UNIT;
            alu_req.c   = A_W'(acc_ff);
            acc_in      = alu_res[NUM_W-1:0];
            state_in    = ST_ADDQ;
         end
         ST_ADDQ: begin
            alu_req.a = A_W'(q_ff >> 2);
            alu_req.b = UNIT;
            alu_req.c = A_W'(acc_ff);
            acc_in    = alu_res[NUM_W-1:0];
            state_in  = ST_ADDMD;
         end
         ST_ADDMD: begin
            // day of month taken as is: the offset of one cancels in the distance
            alu_req.a      = A_W'(month_offset(cur.month)) + A_W'(cur.day);
            alu_req.b      = UNIT;
            alu_req.c      = A_W'(acc_ff);
            num_in[sel_ff] = alu_res[NUM_W-1:0];
            ok_in[sel_ff]  = date_ok;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_DIVY;
            end else begin
               state_in = ST_DIFF1;
            end
         end
         ST_DIFF1: begin
            alu_req.sub = 1'b1;
            alu_req.a   = A_W'(num_ff[1]);
            alu_req.b   = UNIT;
            alu_req.c   = A_W'(num_ff[0]);
            if (alu_res[RES_W-1]) begin
               state_in = ST_DIFF2;
            end else begin
               res_in   = final_res;
               state_in = ST_DONE;
            end
         end
         ST_DIFF2: begin
            alu_req.sub = 1'b1;
            alu_req.a   = A_W'(num_ff[0]);
            alu_req.b   = UNIT;
            alu_req.c   = A_W'(num_ff[1]);
            res_in      = final_res;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
      date_ff <= date_in;
      q_ff    <= q_in;
      leap_ff <= leap_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      ok_ff   <= ok_in;
      res_ff  <= res_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign result     = res_ff;

   // the swapped subtraction only runs after a negative first try
   a_diff2_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIFF2 |-> $past(state_ff) == ST_DIFF1)
      else $error("swapped subtraction without a negative first try");

   a_diff2_sign: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIFF2 |-> !alu_res[RES_W-1])
      else $error("swapped subtraction came out negative");

endmodule

FILE: rtl/gregorian_days_between_dates.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates: day distance between two gregorian dates
// day numbers of both dates through one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
//
// channel   direction  tdata (lowest bit up)                          tuser
// req_      in         first day, month, year, second day, month,   -
//                      year (46 bits in 48)
// rsp_      out        day_count (22 bits in 24)                      invalid_date
//
// an accepted beat goes through these steps until its result beat is shown:
// eight steps of the shared unit per date, one or two for the distance, one
// to hand over, taken in turn on the single multiply-accumulate unit
// req_tready is high only while the sequencer is idle
// the result register frees the sequencer while a result waits on rsp_tready
// reset is synchronous and active high and clears the control state only
//
module gregorian_days_between_dates
   import gdbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // first_day, first_month, first_year,
                                    // second_day, second_month, second_year, zero pad
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // day_count, zero pad
   output logic        rsp_tuser    // invalid_date
);

   logic       seq_idle;
   logic       seq_done;
   logic       seq_take;
   result_type seq_result;
   date_type   first_date;
   date_type   second_date;

   logic       rsp_tvalid_ff, rsp_tvalid_in;
   result_type rsp_data_ff, rsp_data_in;

   // unpack the request beat, first date in the low bits
   assign first_date  = req_tdata[22:0];
   assign second_date = req_tdata[45:23];

   assign req_tready = seq_idle;

   // hand the finished result over when the output register is free or emptying
   assign seq_take = seq_done && (!rsp_tvalid_ff || rsp_tready);

   gdbd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && req_tready),
      .first_date  (first_date),
      .second_date (second_date),
      .take        (seq_take),
      .idle        (seq_idle),
      .done_valid  (seq_done),
      .result      (seq_result)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (seq_take) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = seq_result;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.day_count};
   assign rsp_tuser  = rsp_data_ff.invalid_date;

   // an accepted beat keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the sequencer was still busy");

   // an invalid date always carries a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid date with a non-zero count");

endmodule
